/* sv/vgi_pkg.sv */
package vgi_pkg;

  localparam int VGI_FIELD_WIDTH = 32;

  // Sideband that travels with each radicand through a root pipeline.
  typedef struct packed {
    logic neg;
    logic sat;
  } vgi_tag_t;

endpackage

/* sv/vgi_root.sv */
module vgi_root #(
  parameter int K   = 2,
  parameter int RW  = 64,
  parameter int PAD = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [RW-1:0]         rad,
  input  vgi_pkg::vgi_tag_t     tag_in,
  output logic [RW/K-1:0]       root,
  output vgi_pkg::vgi_tag_t     tag_out
);
  import vgi_pkg::*;

  localparam int N     = RW / K;
  localparam int NS    = N + PAD;
  localparam int REM_W = (K - 1) * N + 5;
  localparam int SQW   = 2 * N;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [N-1:0]     y;
    logic [SQW-1:0]   ysq;
  } acc_t;

  logic [RW-1:0] rad_q [1:NS];
  acc_t          acc_q [1:NS];
  vgi_tag_t      tag_q [1:NS];

  // One binary digit of the root per stage.
  function automatic acc_t step(input acc_t a, input logic [K-1:0] grp);
    acc_t             r;
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    r   = a;
    cur = (a.rem << K) | REM_W'(grp);
    if (K == 2) begin
      trial = (REM_W'(a.y) << 2) | REM_W'(1);
    end else begin
      trial = (REM_W'(a.ysq) << 3) + (REM_W'(a.ysq) << 2) +
              (REM_W'(a.y) << 2) + (REM_W'(a.y) << 1) + REM_W'(1);
    end
    if (cur >= trial) begin
      r.rem = cur - trial;
      r.y   = {a.y[N-2:0], 1'b1};
      r.ysq = (a.ysq << 2) + (SQW'(a.y) << 2) + SQW'(1);
    end else begin
      r.rem = cur;
      r.y   = {a.y[N-2:0], 1'b0};
      r.ysq = a.ysq << 2;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      rad_q[1] <= rad << K;
      acc_q[1] <= step('0, rad[RW-1 -: K]);
      tag_q[1] <= tag_in;
      for (int i = 1; i < NS; i++) begin
        tag_q[i+1] <= tag_q[i];
        if (i < N) begin
          rad_q[i+1] <= rad_q[i] << K;
          acc_q[i+1] <= step(acc_q[i], rad_q[i][RW-1 -: K]);
        end else begin
          rad_q[i+1] <= rad_q[i];
          acc_q[i+1] <= acc_q[i];
        end
      end
    end
  end

  assign root    = acc_q[NS].y;
  assign tag_out = tag_q[NS];

endmodule

/* sv/velocity_gradient_invariants_top.sv */
// Velocity-gradient invariants: one 3x3 gradient matrix in signed Q16.16 is
// accepted per cycle unless in_stall is high, and five saturated Q16.16
// invariants come out in order. Seven stages form the symmetric and
// antisymmetric parts, their squares and the wide traces; the rest is a
// digit-per-stage root pipeline, set by the fourth root, which runs two
// square roots back to back. The whole pipeline holds while a finished
// result is stalled, so in_stall is high while out_valid and out_stall are.
module velocity_gradient_invariants_top #(
  parameter int FIELD_WIDTH = vgi_pkg::VGI_FIELD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [FIELD_WIDTH-1:0] du_dx,
  input  logic signed [FIELD_WIDTH-1:0] dv_dx,
  input  logic signed [FIELD_WIDTH-1:0] dw_dx,
  input  logic signed [FIELD_WIDTH-1:0] du_dy,
  input  logic signed [FIELD_WIDTH-1:0] dv_dy,
  input  logic signed [FIELD_WIDTH-1:0] dw_dy,
  input  logic signed [FIELD_WIDTH-1:0] du_dz,
  input  logic signed [FIELD_WIDTH-1:0] dv_dz,
  input  logic signed [FIELD_WIDTH-1:0] dw_dz,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [FIELD_WIDTH-1:0] strain_sq_root,
  output logic signed [FIELD_WIDTH-1:0] rotation_sq_root,
  output logic signed [FIELD_WIDTH-1:0] strain_cube_root,
  output logic signed [FIELD_WIDTH-1:0] mixed_cube_root,
  output logic signed [FIELD_WIDTH-1:0] mixed_fourth_root
);
  import vgi_pkg::*;

  localparam int W   = FIELD_WIDTH;
  localparam int DW  = W + 1;
  localparam int PW  = 2 * DW;
  localparam int H   = W + 2;
  localparam int EW  = 2 * H;
  localparam int PL  = H + 1 + DW;
  localparam int PH  = H + DW;
  localparam int TW  = 4 * W + 8;
  localparam int LAT = 7 + 3 * W;

  logic           adv;
  logic [LAT:1]   vld;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[LAT-1:1], in_valid};
      out_valid <= vld[LAT];
    end
  end

  // Stage 1: doubled symmetric part (a b c x y z) and antisymmetric part (p r s).
  logic signed [DW-1:0] dm1 [6];
  logic signed [DW-1:0] qv1 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      dm1[0] <= {du_dx, 1'b0};
      dm1[1] <= {dv_dy, 1'b0};
      dm1[2] <= {dw_dz, 1'b0};
      dm1[3] <= $signed({dv_dx[W-1], dv_dx}) + $signed({du_dy[W-1], du_dy});
      dm1[4] <= $signed({dw_dx[W-1], dw_dx}) + $signed({du_dz[W-1], du_dz});
      dm1[5] <= $signed({dw_dy[W-1], dw_dy}) + $signed({dv_dz[W-1], dv_dz});
      qv1[0] <= $signed({dv_dx[W-1], dv_dx}) - $signed({du_dy[W-1], du_dy});
      qv1[1] <= $signed({dw_dx[W-1], dw_dx}) - $signed({du_dz[W-1], du_dz});
      qv1[2] <= $signed({dw_dy[W-1], dw_dy}) - $signed({dv_dz[W-1], dv_dz});
    end
  end

  // Stage 2: element products.
  logic signed [DW-1:0] dm2 [6];
  logic signed [PW-1:0] sq2 [6];
  logic signed [PW-1:0] cr2 [9];
  logic signed [PW-1:0] qs2 [3];
  logic signed [PW-1:0] qc2 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        dm2[i] <= dm1[i];
        sq2[i] <= dm1[i] * dm1[i];
      end
      cr2[0] <= dm1[0] * dm1[3];
      cr2[1] <= dm1[1] * dm1[3];
      cr2[2] <= dm1[4] * dm1[5];
      cr2[3] <= dm1[0] * dm1[4];
      cr2[4] <= dm1[2] * dm1[4];
      cr2[5] <= dm1[3] * dm1[5];
      cr2[6] <= dm1[1] * dm1[5];
      cr2[7] <= dm1[2] * dm1[5];
      cr2[8] <= dm1[3] * dm1[4];
      for (int i = 0; i < 3; i++) begin
        qs2[i] <= qv1[i] * qv1[i];
      end
      qc2[0] <= qv1[1] * qv1[2];
      qc2[1] <= qv1[0] * qv1[2];
      qc2[2] <= qv1[0] * qv1[1];
    end
  end

  // Stage 3: entries of S^2 and R^2 (doubled), and their traces.
  logic signed [DW-1:0] dm3 [6];
  logic signed [EW-1:0] e3  [6];
  logic signed [EW-1:0] f3  [6];
  logic signed [TW-1:0] t2_3, tr_3;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        dm3[i] <= dm2[i];
      end
      e3[0] <= EW'(sq2[0]) + EW'(sq2[3]) + EW'(sq2[4]);
      e3[1] <= EW'(sq2[3]) + EW'(sq2[1]) + EW'(sq2[5]);
      e3[2] <= EW'(sq2[4]) + EW'(sq2[5]) + EW'(sq2[2]);
      e3[3] <= EW'(cr2[0]) + EW'(cr2[1]) + EW'(cr2[2]);
      e3[4] <= EW'(cr2[3]) + EW'(cr2[4]) + EW'(cr2[5]);
      e3[5] <= EW'(cr2[6]) + EW'(cr2[7]) + EW'(cr2[8]);
      f3[0] <= -(EW'(qs2[0]) + EW'(qs2[1]));
      f3[1] <= -(EW'(qs2[0]) + EW'(qs2[2]));
      f3[2] <= -(EW'(qs2[1]) + EW'(qs2[2]));
      f3[3] <= -EW'(qc2[0]);
      f3[4] <= EW'(qc2[1]);
      f3[5] <= -EW'(qc2[2]);
      t2_3  <= TW'(sq2[0]) + TW'(sq2[1]) + TW'(sq2[2]) +
               ((TW'(sq2[3]) + TW'(sq2[4]) + TW'(sq2[5])) <<< 1);
      tr_3  <= -((TW'(qs2[0]) + TW'(qs2[1]) + TW'(qs2[2])) <<< 1);
    end
  end

  // Stage 4: partial products, wide operands split in halves.
  logic signed [PL-1:0]    ped_l [6];
  logic signed [PH-1:0]    ped_h [6];
  logic signed [PL-1:0]    pfd_l [6];
  logic signed [PH-1:0]    pfd_h [6];
  logic signed [2*H+1:0]   pfe_ll [6];
  logic signed [2*H:0]     pfe_lh [6];
  logic signed [2*H:0]     pfe_hl [6];
  logic signed [2*H-1:0]   pfe_hh [6];
  logic signed [TW-1:0]    t2_4, tr_4;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        ped_l[i]  <= $signed({1'b0, e3[i][H-1:0]}) * dm3[i];
        ped_h[i]  <= $signed(e3[i][EW-1:H]) * dm3[i];
        pfd_l[i]  <= $signed({1'b0, f3[i][H-1:0]}) * dm3[i];
        pfd_h[i]  <= $signed(f3[i][EW-1:H]) * dm3[i];
        pfe_ll[i] <= $signed({1'b0, f3[i][H-1:0]}) * $signed({1'b0, e3[i][H-1:0]});
        pfe_lh[i] <= $signed({1'b0, f3[i][H-1:0]}) * $signed(e3[i][EW-1:H]);
        pfe_hl[i] <= $signed(f3[i][EW-1:H]) * $signed({1'b0, e3[i][H-1:0]});
        pfe_hh[i] <= $signed(f3[i][EW-1:H]) * $signed(e3[i][EW-1:H]);
      end
      t2_4 <= t2_3;
      tr_4 <= tr_3;
    end
  end

  // Stage 5: full products, off-diagonal terms counted twice.
  logic signed [TW-1:0] pe5  [6];
  logic signed [TW-1:0] pf5  [6];
  logic signed [TW-1:0] pfe5 [6];
  logic signed [TW-1:0] t2_5, tr_5;
  logic signed [TW-1:0] pe_c  [6];
  logic signed [TW-1:0] pf_c  [6];
  logic signed [TW-1:0] pfe_c [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      pe_c[i]  = (TW'(ped_h[i]) <<< H) + TW'(ped_l[i]);
      pf_c[i]  = (TW'(pfd_h[i]) <<< H) + TW'(pfd_l[i]);
      pfe_c[i] = (TW'(pfe_hh[i]) <<< (2 * H)) +
                 ((TW'(pfe_lh[i]) + TW'(pfe_hl[i])) <<< H) + TW'(pfe_ll[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        pe5[i]  <= (i >= 3) ? (pe_c[i] <<< 1) : pe_c[i];
        pf5[i]  <= (i >= 3) ? (pf_c[i] <<< 1) : pf_c[i];
        pfe5[i] <= (i >= 3) ? (pfe_c[i] <<< 1) : pfe_c[i];
      end
      t2_5 <= t2_4;
      tr_5 <= tr_4;
    end
  end

  // Stage 6: cubic and quartic traces, beside the quadratic ones.
  logic signed [TW-1:0] sum_e, sum_f, sum_fe;
  logic signed [TW-1:0] trc6 [5];

  always_comb begin
    sum_e  = '0;
    sum_f  = '0;
    sum_fe = '0;
    for (int i = 0; i < 6; i++) begin
      sum_e  = sum_e + pe5[i];
      sum_f  = sum_f + pf5[i];
      sum_fe = sum_fe + pfe5[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      trc6[0] <= t2_5;
      trc6[1] <= tr_5;
      trc6[2] <= sum_e;
      trc6[3] <= sum_f;
      trc6[4] <= sum_fe;
    end
  end

  // Stage 7: magnitudes, signs and saturation flags.
  logic [TW-1:0]    mag [5];
  logic [2*W-1:0]   rad_s7, rad_r7;
  logic [3*W-1:0]   rad_c7, rad_m7;
  logic [4*W-1:0]   rad_q7;
  vgi_tag_t         tag7 [5];

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      mag[i] = trc6[i][TW-1] ? TW'(-trc6[i]) : TW'(trc6[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_s7 <= mag[0][2*W-1:0];
      rad_r7 <= mag[1][2*W-1:0];
      rad_c7 <= mag[2][3*W-1:0];
      rad_m7 <= mag[3][3*W-1:0];
      rad_q7 <= mag[4][4*W-1:0];
      for (int i = 0; i < 5; i++) begin
        tag7[i].neg <= trc6[i][TW-1];
      end
      tag7[0].sat <= |mag[0][TW-1:2*W];
      tag7[1].sat <= |mag[1][TW-1:2*W];
      tag7[2].sat <= |mag[2][TW-1:3*W];
      tag7[3].sat <= |mag[3][TW-1:3*W];
      tag7[4].sat <= |mag[4][TW-1:4*W];
    end
  end

  // Root pipelines, each path 3*W stages long; the fourth root chains two of them.
  logic [W-1:0]   root_s, root_r, root_c, root_m, root_q;
  logic [2*W-1:0] root_q1;
  vgi_tag_t       tago [5];
  vgi_tag_t       tag_q1;

  vgi_root #(.K(2), .RW(2 * W), .PAD(2 * W)) u_root_s (
    .clk(clk), .en(adv), .rad(rad_s7), .tag_in(tag7[0]), .root(root_s), .tag_out(tago[0])
  );

  vgi_root #(.K(2), .RW(2 * W), .PAD(2 * W)) u_root_r (
    .clk(clk), .en(adv), .rad(rad_r7), .tag_in(tag7[1]), .root(root_r), .tag_out(tago[1])
  );

  vgi_root #(.K(3), .RW(3 * W), .PAD(2 * W)) u_root_c (
    .clk(clk), .en(adv), .rad(rad_c7), .tag_in(tag7[2]), .root(root_c), .tag_out(tago[2])
  );

  vgi_root #(.K(3), .RW(3 * W), .PAD(2 * W)) u_root_m (
    .clk(clk), .en(adv), .rad(rad_m7), .tag_in(tag7[3]), .root(root_m), .tag_out(tago[3])
  );

  vgi_root #(.K(2), .RW(4 * W), .PAD(0)) u_root_q1 (
    .clk(clk), .en(adv), .rad(rad_q7), .tag_in(tag7[4]), .root(root_q1), .tag_out(tag_q1)
  );

  vgi_root #(.K(2), .RW(2 * W), .PAD(0)) u_root_q2 (
    .clk(clk), .en(adv), .rad(root_q1), .tag_in(tag_q1), .root(root_q), .tag_out(tago[4])
  );

  // The roots are of doubled values, so one shift right gives Q16.16.
  function automatic logic [W-1:0] finish(input logic [W-1:0] z, input vgi_tag_t tg);
    logic [W-1:0] y;
    y = {1'b0, z[W-1:1]};
    if (tg.sat) begin
      return tg.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
    return tg.neg ? (-y) : y;
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      strain_sq_root    <= finish(root_s, tago[0]);
      rotation_sq_root  <= finish(root_r, tago[1]);
      strain_cube_root  <= finish(root_c, tago[2]);
      mixed_cube_root   <= finish(root_m, tago[3]);
      mixed_fourth_root <= finish(root_q, tago[4]);
    end
  end

`ifndef ASSERT_OFF
  a_strain_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !strain_sq_root[W-1])
    else $error("strain square root is negative");

  a_rotation_nonpos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rotation_sq_root[W-1] || rotation_sq_root == '0))
    else $error("rotation square root is positive");

  a_fourth_nonpos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mixed_fourth_root[W-1] || mixed_fourth_root == '0))
    else $error("mixed fourth root is positive");

  a_valid_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vld[LAT]))
    else $error("result transaction without an item in the pipeline");
`endif

endmodule
